@@ rtl/core/lpm_pkg.sv @@
// Shared types and constants for the longest-prefix route lookup block.
// Used by the top level, the prefix compare unit and the port checker.
// No dependencies.
package lpm_pkg;

   localparam int TABLE_ENTRIES = 32;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef struct packed {
      logic        op;
      logic [4:0]  entry_index;
      logic [31:0] entry_dest;
      logic [31:0] entry_mask;
      logic [31:0] entry_gateway;
      logic [2:0]  entry_port;
      logic        entry_valid;
      logic [31:0] lookup_addr;
   } req_type;

   typedef struct packed {
      logic        reachable;
      logic [4:0]  match_slot;
      logic [31:0] next_hop;
      logic [2:0]  out_port;
   } rsp_type;

   // one table row as held in the route RAM
   typedef struct packed {
      logic [31:0] dest;
      logic [31:0] mask;
      logic [31:0] gateway;
      logic [2:0]  port;
   } route_type;

   localparam int ROUTE_W = $bits(route_type);

   // verdict of the prefix compare unit for one row
   typedef struct packed {
      logic hit;
      logic take;
   } cmp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESP
   } lpm_state_type;

endpackage

@@ rtl/core/lpm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ rtl/core/lpm_cmp.sv @@
// Prefix compare unit: decides whether one table row matches the address
// and whether it beats the best row so far. Depends on lpm_pkg.
module lpm_cmp import lpm_pkg::*; (
   input  logic        row_valid,
   input  route_type   row,
   input  logic [31:0] addr,
   input  logic        found,
   input  logic [31:0] best_mask,
   output cmp_type     verdict
);

   always_comb begin
      verdict.hit  = row_valid && ((row.dest & row.mask) == (addr & row.mask));
      // strictly longer only, so the lowest slot keeps a tie
      verdict.take = verdict.hit && (!found || (row.mask > best_mask));
   end

endmodule

@@ rtl/core/longest_prefix_route_lookup.sv @@
// Top level of the IPv4 longest-prefix route lookup block.
// Depends on lpm_pkg, lpm_ram and lpm_cmp.
//
//  channel  | ports                    | handshake
//  ---------+--------------------------+-------------------------------------
//  request  | start, busy, req_data    | taken when start high and busy low
//  result   | rsp_valid, rsp_data      | one-cycle strobe, cannot be held off
//
// A write transaction completes in its accept cycle; busy stays low.
// A lookup holds busy after accept while it reads the route RAM once per
// slot, set by the single RAM read port feeding the one compare unit, then
// passes through a drain state and a result state.
// The result is strobed in the last busy cycle. Reset clears all valid bits.
module longest_prefix_route_lookup import lpm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   lpm_state_type state_ff, state_in;

   logic             valid_ff [TABLE_ENTRIES];
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic             cmp_valid_ff;
   logic [31:0]      addr_ff;

   logic             found_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic [31:0]      best_mask_ff;
   logic [31:0]      best_gw_ff;
   logic [2:0]       best_port_ff;

   logic      accept;
   logic      lookup_go;
   logic      wr_en;
   logic      scanning;
   route_type wr_row;
   route_type rd_row;
   cmp_type   verdict;

   assign accept    = start && !busy;
   assign lookup_go = accept && (req_data.op == OP_LOOKUP);
   assign wr_en     = accept && (req_data.op == OP_WRITE)
                      && (32'(req_data.entry_index) < 32'(TABLE_ENTRIES));

   always_comb begin
      wr_row.dest    = req_data.entry_dest;
      wr_row.mask    = req_data.entry_mask;
      wr_row.gateway = req_data.entry_gateway;
      wr_row.port    = req_data.entry_port;
   end

   lpm_ram #(
      .WIDTH (ROUTE_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_route_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(req_data.entry_index)),
      .wr_data (wr_row),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_row)
   );

   lpm_cmp u_cmp (
      .row_valid (cmp_valid_ff),
      .row       (rd_row),
      .addr      (addr_ff),
      .found     (found_ff),
      .best_mask (best_mask_ff),
      .verdict   (verdict)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (lookup_go) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_RESP;
         ST_RESP:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      scanning  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  busy      = 1'b0;
         ST_SCAN:  scanning  = 1'b1;
         ST_DRAIN: busy      = 1'b1;
         ST_RESP:  rsp_valid = 1'b1;
         default:  busy      = 1'b0;
      endcase
   end

   always_comb begin
      rsp_data.reachable  = found_ff;
      rsp_data.match_slot = 5'(best_idx_ff);
      rsp_data.next_hop   = best_gw_ff;
      rsp_data.out_port   = best_port_ff;
   end

   assign rd_idx_in = scanning ? (rd_idx_ff + IDX_W'(1)) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_idx_ff    <= '0;
         cmp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff  <= state_in;
         rd_idx_ff <= rd_idx_in;
         if (wr_en) begin
            valid_ff[IDX_W'(req_data.entry_index)] <= req_data.entry_valid;
         end
         // valid bit travels alongside the registered RAM read
         cmp_valid_ff <= scanning && valid_ff[rd_idx_ff];
         if (lookup_go) begin
            found_ff <= 1'b0;
         end else if (verdict.take) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= rd_idx_ff;
      if (lookup_go) begin
         addr_ff      <= req_data.lookup_addr;
         best_idx_ff  <= '0;
         best_mask_ff <= '0;
         best_gw_ff   <= '0;
         best_port_ff <= '0;
      end else if (verdict.take) begin
         best_idx_ff  <= cmp_idx_ff;
         best_mask_ff <= rd_row.mask;
         best_gw_ff   <= rd_row.gateway;
         best_port_ff <= rd_row.port;
      end
   end

endmodule

@@ rtl/core/lpm_chk.sv @@
// Port-level checker for the route lookup block, bound to the top level.
// Depends on lpm_pkg.
module lpm_chk import lpm_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // a result only ever closes a lookup in progress
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobed while idle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy && !rsp_valid)
      else $error("block not idle after result");

   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.op == OP_LOOKUP) |=> busy && !rsp_valid)
      else $error("lookup transaction did not start a scan");

   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.op == OP_WRITE) |=> !busy && !rsp_valid)
      else $error("write transaction produced a result or stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.reachable |->
         (rsp_data.match_slot == 5'd0) && (rsp_data.next_hop == 32'd0)
         && (rsp_data.out_port == 3'd0))
      else $error("unreachable result carries nonzero fields");

endmodule

bind longest_prefix_route_lookup lpm_chk u_lpm_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
